[hw/rtl/interval_lane_assigner_core_assert.svh]
// Assertion macros for the interval lane assigner
`ifndef INTERVAL_LANE_ASSIGNER_CORE_ASSERT_SVH
`define INTERVAL_LANE_ASSIGNER_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define ILA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define ILA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/ila_pkg.sv]
// Shared types and constants of the interval lane assigner
package ila_pkg;

    localparam int LANE_SLOTS_DEF  = 16;
    localparam int BATCH_DEPTH_DEF = 1024;

    localparam int START_W    = 11;
    localparam int DUR_W      = 12;
    localparam int END_W      = 13;
    localparam int MAXL_W     = 5;
    localparam int MINX_W     = 11;
    localparam int IDX_W      = 10;
    localparam int LANE_W     = 5;
    localparam int SIZE_W     = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LANES  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_EXTENT = 2'd1;

    localparam logic [MAXL_W-1:0] MAX_LANES_RST  = 5'd3;
    localparam logic [MINX_W-1:0] MIN_EXTENT_RST = 11'd15;

    localparam logic REC_LANE  = 1'b0;
    localparam logic REC_CLOSE = 1'b1;

    typedef struct packed {
        logic [START_W-1:0] start_minutes;
        logic [DUR_W-1:0]   duration_minutes;
        logic               final_item;
    } t_in_word;

    typedef struct packed {
        logic               record_kind;
        logic [IDX_W-1:0]   item_index;
        logic [LANE_W-1:0]  lane_index;
        logic               is_collapsed;
        logic               slot_overflow;
        logic [IDX_W-1:0]   cluster_first;
        logic [SIZE_W-1:0]  cluster_size;
        logic [LANE_W-1:0]  cluster_lanes;
        logic               end_of_run;
    } t_res_word;

    typedef struct packed {
        logic               clear;
        logic               apply;
        logic [START_W-1:0] start;
        logic [END_W-1:0]   iv_end;
    } t_cell_cmd;

    typedef struct packed {
        logic take;
        logic fresh;
    } t_cell_stat;

    typedef struct packed {
        logic take_any;
        logic fresh;
    } t_chain_stat;

endpackage

[hw/rtl/ila_channels.sv]
// Valid/ready channel interfaces for interval words and result words
interface ila_in_if;
    logic             valid;
    logic             ready;
    ila_pkg::t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ila_res_if;
    logic              valid;
    logic              ready;
    ila_pkg::t_res_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/ila_cell.sv]
// One lane cell: holds a lane end and its in-use bit, passes the claim onward
module ila_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ila_pkg::t_cell_cmd  i_cmd,
    input  logic                i_claim,
    output logic                o_claim,
    output ila_pkg::t_cell_stat o_stat
);

    logic                        r_used;
    logic [ila_pkg::END_W-1:0]   r_end;
    logic                        take;

    assign take = !i_claim && (!r_used || (r_end <= ila_pkg::END_W'(i_cmd.start)));
    assign o_claim = i_claim | take;
    assign o_stat.take  = take;
    assign o_stat.fresh = take & !r_used;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= 1'b0;
        end else if (i_cmd.clear) begin
            r_used <= 1'b0;
        end else if (i_cmd.apply && take) begin
            r_used <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.apply && take) begin
            r_end <= i_cmd.iv_end;
        end
    end

endmodule

[hw/rtl/ila_lane_chain.sv]
// Row of lane cells with a rippled claim and lane number encoding
module ila_lane_chain #(
    parameter int LANE_SLOTS = ila_pkg::LANE_SLOTS_DEF,
    localparam int LW = $clog2(LANE_SLOTS + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ila_pkg::t_cell_cmd   i_cmd,
    output ila_pkg::t_chain_stat o_stat,
    output logic [LW-1:0]        o_lane
);

    logic [LANE_SLOTS:0]   claim;
    logic [LANE_SLOTS-1:0] take;
    logic [LANE_SLOTS-1:0] fresh;

    assign claim[0] = 1'b0;

    for (genvar g = 0; g < LANE_SLOTS; g++) begin : g_cell
        ila_pkg::t_cell_stat stat;

        ila_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (i_cmd),
            .i_claim (claim[g]),
            .o_claim (claim[g+1]),
            .o_stat  (stat)
        );

        assign take[g]  = stat.take;
        assign fresh[g] = stat.fresh;
    end

    assign o_stat.take_any = claim[LANE_SLOTS];
    assign o_stat.fresh    = |fresh;

    always_comb begin
        o_lane = LW'(LANE_SLOTS);
        for (int i = 0; i < LANE_SLOTS; i++) begin
            if (take[i]) begin
                o_lane = LW'(i);
            end
        end
    end

endmodule

[hw/rtl/interval_lane_assigner_core.sv]
// Interval lane assigner: greedy lane packing of sorted intervals with cluster records
//
// Channels: i_in takes one interval word (start, duration, final flag) when valid and
// ready are high; o_res gives result words, each either a lane result or a cluster close
// record, with end_of_run set on the last word an interval causes. Registers max_lanes
// and min_extent_minutes are written through i_cfg_we / i_cfg_index / i_cfg_data.
// Sequence: an interval word is taken in the idle state, then a check step decides whether it
// closes the open cluster (close record out), an assign step runs the lane cell row and puts
// out the lane result, and a final interval adds a final step for its close record. The
// control sequencer runs these steps; a new interval word is taken only back in the idle state.
// The lane cells compare all lane ends in parallel, lowest free lane wins.
// Results pass through a one-word output register; a stalled receiver holds the
// sequencer at the step that wants to emit, and input stays blocked meanwhile.
// Reset: registers return to max_lanes 3 and min_extent 15, lanes and cluster state clear.
// A final interval clears lanes, cluster state and the item index after its close record.
module interval_lane_assigner_core #(
    parameter int LANE_SLOTS  = ila_pkg::LANE_SLOTS_DEF,
    parameter int BATCH_DEPTH = ila_pkg::BATCH_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ila_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ila_pkg::CFG_DATA_W-1:0] i_cfg_data,
    ila_in_if.sink                         i_in,
    ila_res_if.source                      o_res
);

    `include "interval_lane_assigner_core_assert.svh"

    localparam int LW = $clog2(LANE_SLOTS + 1);
    localparam int CW = (LW > ila_pkg::MAXL_W) ? LW : ila_pkg::MAXL_W;
    localparam int BW = $clog2(BATCH_DEPTH);
    localparam int MW = $clog2(BATCH_DEPTH + 1);
    localparam int EW = ila_pkg::END_W;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_CHECK  = 2'd1;
    localparam logic [1:0] S_ASSIGN = 2'd2;
    localparam logic [1:0] S_FINAL  = 2'd3;

    logic [ila_pkg::MAXL_W-1:0]  r_max_lanes;
    logic [ila_pkg::MINX_W-1:0]  r_min_extent;
    logic [1:0]                  r_state;
    logic [ila_pkg::START_W-1:0] r_start;
    logic [ila_pkg::DUR_W-1:0]   r_dur;
    logic                        r_fin;
    logic [EW-1:0]               r_iv_end;
    logic [LW-1:0]               r_lanes_in_use;
    logic [EW-1:0]               r_cluster_end;
    logic                        r_cluster_open;
    logic [BW-1:0]               r_cluster_start;
    logic [BW-1:0]               r_next_index;
    logic [MW-1:0]               r_member_count;
    logic                        r_out_valid;
    ila_pkg::t_res_word          r_out_word;

    logic [CW-1:0]               eff_max;
    logic [CW-1:0]               close_lanes;
    logic                        can_emit;
    logic                        close_now;
    logic [ila_pkg::DUR_W-1:0]   ext;
    logic [EW-1:0]               n_iv_end;
    logic                        emit_close_chk;
    logic                        emit_iv;
    logic                        emit_fin;
    ila_pkg::t_res_word          close_word;
    ila_pkg::t_res_word          lane_word;
    ila_pkg::t_cell_cmd          cell_cmd;
    ila_pkg::t_chain_stat        chain_stat;
    logic [LW-1:0]               chain_lane;

    always_comb begin
        eff_max = CW'(r_max_lanes);
        if (eff_max == '0) begin
            eff_max = CW'(1);
        end else if (eff_max > CW'(LANE_SLOTS)) begin
            eff_max = CW'(LANE_SLOTS);
        end
        close_lanes = CW'(r_lanes_in_use);
        if (close_lanes == '0) begin
            close_lanes = CW'(1);
        end
        if (close_lanes > eff_max) begin
            close_lanes = eff_max;
        end
    end

    assign can_emit  = !r_out_valid || o_res.ready;
    assign close_now = r_cluster_open && (EW'(r_start) >= r_cluster_end);
    assign ext       = (r_dur > ila_pkg::DUR_W'(r_min_extent)) ? r_dur
                                                              : ila_pkg::DUR_W'(r_min_extent);
    assign n_iv_end  = EW'(r_start) + EW'(ext);

    assign emit_close_chk = (r_state == S_CHECK) && close_now && can_emit;
    assign emit_iv        = (r_state == S_ASSIGN) && can_emit;
    assign emit_fin       = (r_state == S_FINAL) && can_emit;

    always_comb begin
        close_word               = '0;
        close_word.record_kind   = ila_pkg::REC_CLOSE;
        close_word.cluster_first = ila_pkg::IDX_W'(r_cluster_start);
        close_word.cluster_size  = ila_pkg::SIZE_W'(r_member_count);
        close_word.cluster_lanes = ila_pkg::LANE_W'(close_lanes);
        close_word.end_of_run    = (r_state == S_FINAL);

        lane_word               = '0;
        lane_word.record_kind   = ila_pkg::REC_LANE;
        lane_word.item_index    = ila_pkg::IDX_W'(r_next_index);
        lane_word.lane_index    = ila_pkg::LANE_W'(chain_lane);
        lane_word.is_collapsed  = (CW'(chain_lane) >= eff_max);
        lane_word.slot_overflow = !chain_stat.take_any;
        lane_word.end_of_run    = !r_fin;
    end

    assign cell_cmd.clear  = emit_close_chk || emit_fin;
    assign cell_cmd.apply  = emit_iv;
    assign cell_cmd.start  = r_start;
    assign cell_cmd.iv_end = r_iv_end;

    ila_lane_chain #(
        .LANE_SLOTS (LANE_SLOTS)
    ) u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cell_cmd),
        .o_stat  (chain_stat),
        .o_lane  (chain_lane)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_lanes  <= ila_pkg::MAX_LANES_RST;
            r_min_extent <= ila_pkg::MIN_EXTENT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ila_pkg::CFG_MAX_LANES: begin
                    r_max_lanes <= ila_pkg::MAXL_W'(i_cfg_data);
                end
                ila_pkg::CFG_MIN_EXTENT: begin
                    r_min_extent <= ila_pkg::MINX_W'(i_cfg_data);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_lanes_in_use  <= '0;
            r_cluster_end   <= '0;
            r_cluster_open  <= 1'b0;
            r_cluster_start <= '0;
            r_next_index    <= '0;
            r_member_count  <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (emit_close_chk || emit_iv || emit_fin) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (!close_now) begin
                        r_state <= S_ASSIGN;
                    end else if (can_emit) begin
                        r_lanes_in_use  <= '0;
                        r_cluster_start <= r_next_index;
                        r_member_count  <= '0;
                        r_cluster_open  <= 1'b0;
                        r_state         <= S_ASSIGN;
                    end
                end
                S_ASSIGN: begin
                    if (can_emit) begin
                        if (chain_stat.fresh) begin
                            r_lanes_in_use <= r_lanes_in_use + LW'(1);
                        end
                        if (!r_cluster_open || (r_iv_end > r_cluster_end)) begin
                            r_cluster_end <= r_iv_end;
                        end
                        r_cluster_open <= 1'b1;
                        if (r_member_count < MW'(BATCH_DEPTH)) begin
                            r_member_count <= r_member_count + MW'(1);
                        end
                        if (r_next_index == BW'(BATCH_DEPTH - 1)) begin
                            r_next_index <= '0;
                        end else begin
                            r_next_index <= r_next_index + BW'(1);
                        end
                        r_state <= r_fin ? S_FINAL : S_IDLE;
                    end
                end
                S_FINAL: begin
                    if (can_emit) begin
                        r_lanes_in_use  <= '0;
                        r_cluster_end   <= '0;
                        r_cluster_open  <= 1'b0;
                        r_cluster_start <= '0;
                        r_next_index    <= '0;
                        r_member_count  <= '0;
                        r_state         <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_in.valid) begin
            r_start <= i_in.data.start_minutes;
            r_dur   <= i_in.data.duration_minutes;
            r_fin   <= i_in.data.final_item;
        end
        if (r_state == S_CHECK) begin
            r_iv_end <= n_iv_end;
        end
        if (emit_close_chk || emit_fin) begin
            r_out_word <= close_word;
        end else if (emit_iv) begin
            r_out_word <= lane_word;
        end
    end

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out_word;

    `ILA_ASSERT_NOW(a_overflow_full, emit_iv && !chain_stat.take_any,
        r_lanes_in_use == LW'(LANE_SLOTS), "slot overflow with a lane still free")
    `ILA_ASSERT_NOW(a_open_has_members, r_cluster_open,
        r_member_count != '0, "open cluster without members")
    `ILA_ASSERT_NEXT(a_final_clears, emit_fin,
        (r_lanes_in_use == '0) && !r_cluster_open && (r_next_index == '0),
        "state not cleared after final close")
    `ILA_ASSERT_NOW(a_lanes_bound, r_cluster_open,
        r_lanes_in_use <= LW'(LANE_SLOTS), "lane count beyond slot count")

endmodule
